>>> hdl/clipped_keyed_sprite_blit_defines.svh
// Assertion macros used by the sprite blitter top level.
`ifndef CLIPPED_KEYED_SPRITE_BLIT_DEFINES_SVH
`define CLIPPED_KEYED_SPRITE_BLIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CKB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CKB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`else

`define CKB_ASSERT_IMP(label, clk, rst_n, pre, post)
`define CKB_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> hdl/ckblit_pkg.sv
// Package with constants, register codes and types of the sprite blitter.
`timescale 1ns / 1ps

package ckblit_pkg;

    // Screen and atlas geometry.
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 64;
    localparam int ATLAS_WIDTH   = 80;
    localparam int ATLAS_ROWS    = 256;
    localparam int ATLAS_SIZE    = ATLAS_ROWS * ATLAS_WIDTH;
    localparam int SCREEN_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

    // Field widths.
    localparam int PIXEL_W  = 32;
    localparam int ADDR_W   = 13;
    localparam int COLOR_W  = 16;
    localparam int FETCH_W  = 15;
    localparam int COUNT_W  = 7;
    localparam int DEST_W   = 8;
    localparam int SRCX_W   = 7;
    localparam int SRCY_W   = 8;
    localparam int LIN_W    = 16;
    localparam int POS_W    = DEST_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_DATA_W = 48;

    // Bit 31 of a source pixel marks it opaque.
    localparam int OPAQUE_BIT = 31;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEST_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd5;

    // Reset values of the rectangle size.
    localparam logic [COUNT_W-1:0] RESET_WIDTH  = 7'd80;
    localparam logic [COUNT_W-1:0] RESET_HEIGHT = 7'd32;

    typedef struct packed {
        logic [DEST_W-1:0]  dest_x;
        logic [DEST_W-1:0]  dest_y;
        logic [SRCX_W-1:0]  source_x;
        logic [SRCY_W-1:0]  source_y;
        logic [COUNT_W-1:0] rect_width;
        logic [COUNT_W-1:0] rect_height;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0] col;
        logic [COUNT_W-1:0] row;
    } t_pos;

    typedef struct packed {
        logic [ADDR_W-1:0]  fb_address;
        logic [COLOR_W-1:0] fb_color;
        logic               write_enable;
        logic [FETCH_W-1:0] fetch_index;
        logic               last_pixel;
    } t_result;

endpackage

>>> hdl/ckblit_pixel.sv
// Per-pixel datapath: color conversion, clipping, address, counter step and atlas index.
`timescale 1ns / 1ps

module ckblit_pixel (
    input  ckblit_pkg::t_cfg                   i_cfg,
    input  ckblit_pkg::t_pos                   i_pos,
    input  logic [ckblit_pkg::PIXEL_W-1:0]     i_pixel,
    output ckblit_pkg::t_result                o_result,
    output ckblit_pkg::t_pos                   o_pos_next
);

    logic                                 empty;
    logic [15:0]                          rgb565;
    logic [ckblit_pkg::POS_W-1:0]         scr_col;
    logic [ckblit_pkg::POS_W-1:0]         scr_row;
    logic                                 on_screen;
    logic [ckblit_pkg::COUNT_W-1:0]       col_inc;
    logic [ckblit_pkg::COUNT_W-1:0]       row_inc;
    logic                                 wrap_row;
    logic                                 wrap_all;
    ckblit_pkg::t_pos                     pos_next;
    logic [ckblit_pkg::LIN_W-1:0]         lin;
    logic [ckblit_pkg::LIN_W-1:0]         lin_wrapped;
    logic [ckblit_pkg::ADDR_W-1:0]        addr;

    assign empty = (i_cfg.rect_width == '0) || (i_cfg.rect_height == '0);

    // 8-8-8 to 565, then swap the two bytes.
    assign rgb565 = {i_pixel[7:3], i_pixel[15:10], i_pixel[23:19]};
    assign o_result.fb_color = {rgb565[7:0], rgb565[15:8]};

    // Screen position of this pixel, signed destination plus counter.
    assign scr_col = {{2{i_cfg.dest_x[ckblit_pkg::DEST_W-1]}}, i_cfg.dest_x}
                   + {3'b000, i_pos.col};
    assign scr_row = {{2{i_cfg.dest_y[ckblit_pkg::DEST_W-1]}}, i_cfg.dest_y}
                   + {3'b000, i_pos.row};

    // Clip at the left, right, top and bottom edges; an empty rectangle is never on screen.
    assign on_screen = !empty
        && !scr_col[ckblit_pkg::POS_W-1]
        && (scr_col < ckblit_pkg::POS_W'(ckblit_pkg::SCREEN_WIDTH))
        && !scr_row[ckblit_pkg::POS_W-1]
        && (scr_row < ckblit_pkg::POS_W'(ckblit_pkg::SCREEN_HEIGHT));

    assign addr = ckblit_pkg::ADDR_W'(scr_row) * ckblit_pkg::ADDR_W'(ckblit_pkg::SCREEN_WIDTH)
                + ckblit_pkg::ADDR_W'(scr_col);
    assign o_result.fb_address   = on_screen ? addr : '0;
    assign o_result.write_enable = on_screen && i_pixel[ckblit_pkg::OPAQUE_BIT];

    // Raster step of the column and row counters.
    assign col_inc  = i_pos.col + 1'b1;
    assign row_inc  = i_pos.row + 1'b1;
    assign wrap_row = col_inc >= i_cfg.rect_width;
    assign wrap_all = wrap_row && (row_inc >= i_cfg.rect_height);

    always_comb begin
        pos_next.col = col_inc;
        pos_next.row = i_pos.row;
        if (empty) begin
            pos_next = '0;
        end else if (wrap_row) begin
            pos_next.col = '0;
            pos_next.row = wrap_all ? '0 : row_inc;
        end
    end

    assign o_pos_next          = pos_next;
    assign o_result.last_pixel = empty || wrap_all;

    // Atlas index of the next pixel; the sum stays below twice the atlas size.
    assign lin = (ckblit_pkg::LIN_W'(i_cfg.source_y) + ckblit_pkg::LIN_W'(pos_next.row))
               * ckblit_pkg::LIN_W'(ckblit_pkg::ATLAS_WIDTH)
               + ckblit_pkg::LIN_W'(i_cfg.source_x) + ckblit_pkg::LIN_W'(pos_next.col);
    assign lin_wrapped = (lin >= ckblit_pkg::LIN_W'(ckblit_pkg::ATLAS_SIZE))
                       ? lin - ckblit_pkg::LIN_W'(ckblit_pkg::ATLAS_SIZE) : lin;
    assign o_result.fetch_index = lin_wrapped[ckblit_pkg::FETCH_W-1:0];

endmodule

>>> hdl/clipped_keyed_sprite_blit.sv
// Top level of the clipped, color-keyed sprite blitter.
//
// Channel   Dir  Handshake              Contents
// s_*       in   i_s_tvalid/o_s_tready  tdata: pixel_argb[31:0]
// m_*       out  o_m_tvalid/i_m_tready  tdata, tuser: write_enable, tlast: last_pixel
// cfg_*     in   i_cfg_valid/o_cfg_ready  register index and write data
//
// One pixel per cycle while the output is taken; each request passes through an input
// register and a result register with the per-pixel logic between them.
// While the result register is full and not taken, the input register still takes
// one request; after that the input stalls until the result is taken.
// Reset restores the register defaults and restarts the rectangle; a
// configuration write to a known register index restarts it as well.
`timescale 1ns / 1ps
`include "clipped_keyed_sprite_blit_defines.svh"

module clipped_keyed_sprite_blit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Source pixel stream.
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [ckblit_pkg::PIXEL_W-1:0]         i_s_tdata,   // [31:0] pixel_argb
    // Framebuffer write stream.
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // [12:0] fb_address, [28:13] fb_color, [43:29] fetch_index, [47:44] zero
    output logic [ckblit_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic                                   o_m_tuser,   // [0] write_enable
    output logic                                   o_m_tlast,
    // Configuration writes.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ckblit_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ckblit_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    ckblit_pkg::t_cfg                       r_cfg;
    ckblit_pkg::t_pos                       r_pos;
    ckblit_pkg::t_pos                       pos_next;
    ckblit_pkg::t_result                    result;
    ckblit_pkg::t_result                    r_out;
    logic [ckblit_pkg::PIXEL_W-1:0]         r_pix;
    logic                                   r_pix_valid;
    logic                                   r_out_valid;
    logic                                   stage_free;
    logic                                   advance;
    logic                                   in_accept;
    logic                                   cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    // Handshake control of the two pipeline registers.
    assign stage_free = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_pix_valid || stage_free;
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign advance    = r_pix_valid && stage_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_x      <= '0;
            r_cfg.dest_y      <= '0;
            r_cfg.source_x    <= '0;
            r_cfg.source_y    <= '0;
            r_cfg.rect_width  <= ckblit_pkg::RESET_WIDTH;
            r_cfg.rect_height <= ckblit_pkg::RESET_HEIGHT;
        end else if (cfg_write) begin
            case (i_cfg_index)
                ckblit_pkg::REG_DEST_X:      r_cfg.dest_x   <= i_cfg_data;
                ckblit_pkg::REG_DEST_Y:      r_cfg.dest_y   <= i_cfg_data;
                ckblit_pkg::REG_SOURCE_X:
                    r_cfg.source_x <= i_cfg_data[ckblit_pkg::SRCX_W-1:0];
                ckblit_pkg::REG_SOURCE_Y:    r_cfg.source_y <= i_cfg_data;
                ckblit_pkg::REG_RECT_WIDTH:
                    r_cfg.rect_width <= i_cfg_data[ckblit_pkg::COUNT_W-1:0];
                ckblit_pkg::REG_RECT_HEIGHT:
                    r_cfg.rect_height <= i_cfg_data[ckblit_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Raster counters; a write to a known register restarts the rectangle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (cfg_write && (i_cfg_index <= ckblit_pkg::REG_RECT_HEIGHT)) begin
            r_pos <= '0;
        end else if (advance) begin
            r_pos <= pos_next;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (in_accept) begin
            r_pix_valid <= 1'b1;
        end else if (advance) begin
            r_pix_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pix <= i_s_tdata;
        end
    end

    ckblit_pixel u_pixel (
        .i_cfg      (r_cfg),
        .i_pos      (r_pos),
        .i_pixel    (r_pix),
        .o_result   (result),
        .o_pos_next (pos_next)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_free) begin
            r_out_valid <= r_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.fetch_index, r_out.fb_color, r_out.fb_address};
    assign o_m_tuser  = r_out.write_enable;
    assign o_m_tlast  = r_out.last_pixel;

    // Counters stay inside a non-empty rectangle.
    `CKB_ASSERT_IMP(a_col_in_rect, i_clk, i_rst_n,
        r_cfg.rect_width != '0, r_pos.col < r_cfg.rect_width)
    `CKB_ASSERT_IMP(a_row_in_rect, i_clk, i_rst_n,
        r_cfg.rect_height != '0, r_pos.row < r_cfg.rect_height)
    // A write only lands on the screen.
    `CKB_ASSERT_IMP(a_addr_on_screen, i_clk, i_rst_n,
        r_out_valid && r_out.write_enable,
        r_out.fb_address < ckblit_pkg::ADDR_W'(ckblit_pkg::SCREEN_PIXELS))
    // The last pixel of a rectangle restarts the raster.
    `CKB_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n,
        advance && result.last_pixel, r_pos == '0)
    // A pixel in the input register moves on when the result register is free.
    `CKB_ASSERT_NEXT(a_pipe_moves, i_clk, i_rst_n, advance, r_out_valid)

endmodule
